/* hdl/stcc_pkg.sv */
`timescale 1ns / 1ps
package stcc_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_SEP  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [1:0] SRC_LOAD  = 2'd0;
  localparam logic [1:0] SRC_MATCH = 2'd1;
  localparam logic [1:0] SRC_ROOT  = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       set_pending;
    logic       start_seek;
    logic [1:0] seek_src;
    logic       rd_scan;
    logic       scan_next;
    logic       load_hit;
    logic       load_new;
    logic       load_fail;
    logic       match_hit;
    logic       walk_start;
    logic       rd_walk;
    logic       walk_push;
    logic       walk_end;
    logic       rd_load;
    logic       assign_write;
    logic       assign_error;
    logic       sep_clear;
    logic       set_want;
    logic       emit_head;
    logic       emit_tail;
    logic       emit_code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] kind;
    logic       expect_result;
    logic       load_active;
    logic       match_active;
    logic       scan_done;
    logic       hit;
    logic       can_create;
    logic       walk_cont;
    logic       conflict;
    logic       k_zero;
    logic       k_one;
    logic       want_code;
  } sts_t;

endpackage

/* hdl/stcc_ram.sv */
`timescale 1ns / 1ps
module stcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/stcc_ctrl.sv */
`timescale 1ns / 1ps
module stcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  stcc_pkg::sts_t sts,
  output stcc_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_SRD  = 4'd2;
  localparam logic [3:0] ST_SCMP = 4'd3;
  localparam logic [3:0] ST_WRD  = 4'd4;
  localparam logic [3:0] ST_WCHK = 4'd5;
  localparam logic [3:0] ST_ARD  = 4'd6;
  localparam logic [3:0] ST_ACHK = 4'd7;
  localparam logic [3:0] ST_EMH  = 4'd8;
  localparam logic [3:0] ST_EMT  = 4'd9;
  localparam logic [3:0] ST_EMC  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] purp_r, purp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      purp_r  <= stcc_pkg::SRC_LOAD;
    end else begin
      state_r <= state_nxt;
      purp_r  <= purp_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    purp_nxt  = purp_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_IDLE;
        if (sts.mode == stcc_pkg::MODE_LOAD) begin
          if (sts.kind == stcc_pkg::KIND_CHAR) begin
            if (sts.expect_result) begin
              cmd.set_pending = 1'b1;
            end else begin
              cmd.start_seek = 1'b1;
              cmd.seek_src   = stcc_pkg::SRC_LOAD;
              purp_nxt       = stcc_pkg::SRC_LOAD;
              state_nxt      = ST_SRD;
            end
          end else if ((sts.kind == stcc_pkg::KIND_SEP || sts.kind == stcc_pkg::KIND_END)
                       && !sts.expect_result) begin
            if (sts.load_active) begin
              cmd.rd_load = 1'b1;
              state_nxt   = ST_ACHK;
            end else begin
              cmd.sep_clear = 1'b1;
            end
          end
        end else if (sts.mode == stcc_pkg::MODE_DATA) begin
          cmd.start_seek = 1'b1;
          cmd.seek_src   = stcc_pkg::SRC_MATCH;
          purp_nxt       = stcc_pkg::SRC_MATCH;
          state_nxt      = ST_SRD;
        end else if (sts.mode == stcc_pkg::MODE_FLUSH) begin
          if (sts.match_active) begin
            cmd.walk_start = 1'b1;
            purp_nxt       = stcc_pkg::SRC_ROOT;
            state_nxt      = ST_WRD;
          end
        end
      end
      ST_SRD: begin
        if (sts.scan_done) begin
          state_nxt = ST_IDLE;
          case (purp_r)
            stcc_pkg::SRC_LOAD: begin
              if (sts.can_create) begin
                cmd.load_new = 1'b1;
              end else begin
                cmd.load_fail = 1'b1;
              end
            end
            stcc_pkg::SRC_MATCH: begin
              if (sts.match_active) begin
                cmd.walk_start = 1'b1;
                state_nxt      = ST_WRD;
              end else begin
                cmd.emit_code = 1'b1;
              end
            end
            default: begin
              cmd.set_want = 1'b1;
              state_nxt    = ST_EMH;
            end
          endcase
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = ST_SCMP;
        end
      end
      ST_SCMP: begin
        if (sts.hit) begin
          state_nxt = ST_IDLE;
          if (purp_r == stcc_pkg::SRC_LOAD) begin
            cmd.load_hit = 1'b1;
          end else begin
            cmd.match_hit = 1'b1;
            if (purp_r == stcc_pkg::SRC_ROOT) begin
              state_nxt = ST_EMH;
            end
          end
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = ST_SRD;
        end
      end
      ST_WRD: begin
        cmd.rd_walk = 1'b1;
        state_nxt   = ST_WCHK;
      end
      ST_WCHK: begin
        if (sts.walk_cont) begin
          cmd.walk_push = 1'b1;
          state_nxt     = ST_WRD;
        end else begin
          cmd.walk_end = 1'b1;
          if (purp_r == stcc_pkg::SRC_MATCH) begin
            cmd.start_seek = 1'b1;
            cmd.seek_src   = stcc_pkg::SRC_ROOT;
            purp_nxt       = stcc_pkg::SRC_ROOT;
            state_nxt      = ST_SRD;
          end else begin
            state_nxt = ST_EMH;
          end
        end
      end
      ST_ARD: begin
        cmd.rd_load = 1'b1;
        state_nxt   = ST_ACHK;
      end
      ST_ACHK: begin
        if (sts.conflict) begin
          cmd.assign_error = 1'b1;
        end else begin
          cmd.assign_write = 1'b1;
        end
        cmd.sep_clear = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_EMH: begin
        cmd.emit_head = 1'b1;
        if (!sts.k_zero) begin
          state_nxt = ST_EMT;
        end else if (sts.want_code) begin
          state_nxt = ST_EMC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMT: begin
        cmd.emit_tail = 1'b1;
        if (sts.k_one) begin
          state_nxt = sts.want_code ? ST_EMC : ST_IDLE;
        end
      end
      ST_EMC: begin
        cmd.emit_code = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/stcc_datapath.sv */
`timescale 1ns / 1ps
module stcc_datapath #(
  parameter int NODE_COUNT = 256,
  parameter int MAX_DEPTH  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     in_mode,
  input  logic [15:0]    in_code,
  input  logic [1:0]     in_word_kind,
  input  stcc_pkg::cmd_t cmd,
  output stcc_pkg::sts_t sts,
  output logic           out_strobe,
  output logic [15:0]    out_code,
  output logic           out_last_of_run,
  output logic           out_table_error
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int TW = $clog2(MAX_DEPTH);
  localparam int W  = DW + AW + 34;

  logic [1:0]    mode_r, kind_r;
  logic [15:0]   code_r;
  logic [AW:0]   scan_r, nodes_used_r;
  logic          seek_under_r;
  logic [AW-1:0] seek_parent_r;
  logic [AW-1:0] match_node_r, load_node_r, walk_n_r;
  logic          match_active_r, load_active_r, expect_r, err_r, want_r;
  logic [DW-1:0] load_depth_r;
  logic [15:0]   pending_r, head_r;
  logic [DW-1:0] k_r;
  logic [15:0]   tail_r [MAX_DEPTH];
  logic          strobe_r, last_r;
  logic [15:0]   ocode_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata;
  logic [15:0]   rd_code, rd_result;
  logic          rd_has, rd_root;
  logic [AW-1:0] rd_parent;
  logic [DW-1:0] rd_depth, new_depth, k_m1;

  assign rd_depth  = rdata[DW-1:0];
  assign rd_parent = rdata[DW+AW-1:DW];
  assign rd_root   = rdata[DW+AW];
  assign rd_has    = rdata[DW+AW+1];
  assign rd_result = rdata[DW+AW+17:DW+AW+2];
  assign rd_code   = rdata[DW+AW+33:DW+AW+18];

  assign new_depth = load_active_r ? load_depth_r + 1'b1 : DW'(1);
  assign k_m1      = k_r - 1'b1;

  always_comb begin
    raddr = scan_r[AW-1:0];
    if (cmd.rd_walk) begin
      raddr = walk_n_r;
    end else if (cmd.rd_load) begin
      raddr = load_node_r;
    end
  end

  always_comb begin
    we    = cmd.load_new | cmd.assign_write;
    waddr = cmd.load_new ? nodes_used_r[AW-1:0] : load_node_r;
    if (cmd.load_new) begin
      wdata = {code_r, (load_active_r ? 16'h0000 : code_r), !load_active_r, !load_active_r,
               (load_active_r ? load_node_r : AW'(0)), new_depth};
    end else begin
      wdata = {rd_code, pending_r, 1'b1, rd_root, rd_parent, rd_depth};
    end
  end

  stcc_ram #(.WIDTH(W), .DEPTH(NODE_COUNT)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_used_r   <= '0;
      match_node_r   <= '0;
      match_active_r <= 1'b0;
      load_node_r    <= '0;
      load_active_r  <= 1'b0;
      load_depth_r   <= '0;
      expect_r       <= 1'b1;
      pending_r      <= '0;
      err_r          <= 1'b0;
      k_r            <= '0;
      want_r         <= 1'b0;
      strobe_r       <= 1'b0;
    end else begin
      strobe_r <= cmd.emit_head | cmd.emit_tail | cmd.emit_code;
      if (cmd.set_pending) begin
        pending_r <= code_r;
        expect_r  <= 1'b0;
      end
      if (cmd.load_hit) begin
        load_node_r   <= scan_r[AW-1:0];
        load_active_r <= 1'b1;
        load_depth_r  <= rd_depth;
      end
      if (cmd.load_new) begin
        nodes_used_r  <= nodes_used_r + 1'b1;
        load_node_r   <= nodes_used_r[AW-1:0];
        load_active_r <= 1'b1;
        load_depth_r  <= new_depth;
      end
      if (cmd.load_fail) begin
        err_r         <= 1'b1;
        load_active_r <= 1'b0;
      end
      if (cmd.assign_error) begin
        err_r <= 1'b1;
      end
      if (cmd.sep_clear) begin
        load_active_r <= 1'b0;
        load_node_r   <= '0;
        if (kind_r == stcc_pkg::KIND_END) begin
          expect_r <= 1'b1;
        end
      end
      if (cmd.match_hit) begin
        match_node_r   <= scan_r[AW-1:0];
        match_active_r <= 1'b1;
      end
      if (cmd.walk_start) begin
        k_r    <= '0;
        want_r <= 1'b0;
      end
      if (cmd.walk_push) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.walk_end) begin
        match_active_r <= 1'b0;
      end
      if (cmd.set_want) begin
        want_r <= 1'b1;
      end
      if (cmd.emit_tail) begin
        k_r <= k_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      code_r <= in_code;
      kind_r <= in_word_kind;
    end
    if (cmd.start_seek) begin
      scan_r <= '0;
      case (cmd.seek_src)
        stcc_pkg::SRC_LOAD: begin
          seek_under_r  <= load_active_r;
          seek_parent_r <= load_node_r;
        end
        stcc_pkg::SRC_MATCH: begin
          seek_under_r  <= match_active_r;
          seek_parent_r <= match_node_r;
        end
        default: begin
          seek_under_r  <= 1'b0;
          seek_parent_r <= '0;
        end
      endcase
    end
    if (cmd.scan_next) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.walk_start) begin
      walk_n_r <= match_node_r;
    end
    if (cmd.walk_push) begin
      tail_r[k_r[TW-1:0]] <= rd_code;
      walk_n_r            <= rd_parent;
    end
    if (cmd.walk_end) begin
      head_r <= rd_result;
    end
    if (cmd.emit_head) begin
      ocode_r <= head_r;
      last_r  <= (k_r == '0) && !want_r;
    end
    if (cmd.emit_tail) begin
      ocode_r <= tail_r[k_m1[TW-1:0]];
      last_r  <= (k_r == DW'(1)) && !want_r;
    end
    if (cmd.emit_code) begin
      ocode_r <= code_r;
      last_r  <= 1'b1;
    end
  end

  assign sts.mode          = mode_r;
  assign sts.kind          = kind_r;
  assign sts.expect_result = expect_r;
  assign sts.load_active   = load_active_r;
  assign sts.match_active  = match_active_r;
  assign sts.scan_done     = (scan_r >= nodes_used_r);
  assign sts.hit           = (rd_code == code_r) &&
                             (seek_under_r ? (!rd_root && rd_parent == seek_parent_r) : rd_root);
  assign sts.can_create    = (nodes_used_r < (AW+1)'(NODE_COUNT)) &&
                             !(load_active_r && load_depth_r >= DW'(MAX_DEPTH));
  assign sts.walk_cont     = !rd_has && !rd_root && (k_r < DW'(MAX_DEPTH));
  assign sts.conflict      = rd_has && !(rd_root && rd_result == rd_code);
  assign sts.k_zero        = (k_r == '0);
  assign sts.k_one         = (k_r == DW'(1));
  assign sts.want_code     = want_r;

  assign out_strobe      = strobe_r;
  assign out_code        = ocode_r;
  assign out_last_of_run = last_r;
  assign out_table_error = err_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= (AW+1)'(NODE_COUNT)) else $error("node count overflow");
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= DW'(MAX_DEPTH)) else $error("tail stack overflow");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_depth_r <= DW'(MAX_DEPTH)) else $error("load depth overflow");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r) else $error("error flag dropped");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.emit_head, cmd.emit_tail, cmd.emit_code}) <= 1)
    else $error("two emits at once");

endmodule

/* hdl/sequence_to_code_combiner.sv */
`timescale 1ns / 1ps
// Channel  Ports                                          Handshake
// input    in_mode, in_code, in_word_kind                 start & !busy
// result   out_code, out_last_of_run, out_table_error     out_strobe, one cycle
//
// A child search reads the stored nodes one at a time, a read state and a compare
// state per node, up to nodes_used nodes; a miss in the match walks back one level
// at a time up the parent chain, then runs a root search and emits the words in turn.
// Table loads with a result or separator word run without a node search.
// Synchronous active-low reset clears the control state and the node count;
// the node store needs no clearing pass. Results cannot be held off.
module sequence_to_code_combiner #(
  parameter int NODE_COUNT = 256,
  parameter int MAX_DEPTH  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_code,
  input  logic [1:0]  in_word_kind,
  output logic        out_strobe,
  output logic [15:0] out_code,
  output logic        out_last_of_run,
  output logic        out_table_error
);

  stcc_pkg::cmd_t cmd;
  stcc_pkg::sts_t sts;

  stcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  stcc_datapath #(.NODE_COUNT(NODE_COUNT), .MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_code         (in_code),
    .in_word_kind    (in_word_kind),
    .cmd             (cmd),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .out_code        (out_code),
    .out_last_of_run (out_last_of_run),
    .out_table_error (out_table_error)
  );

endmodule
